@@ design/vertex_normal_accumulator_macros.svh @@
// ----------------------------------------------------------------------------
// Vertex normal accumulator assertion macros
// Shared concurrent assertion shorthands for the accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VNA_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VNA_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/vna_pkg.sv @@
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Widths, the queued triangle type and the corner sequencing codes.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int IDX_W       = 12;
  localparam int COORD_W     = 16;
  localparam int EDGE_W      = 17;
  localparam int PROD_W      = 34;
  localparam int NRM_W       = 35;
  localparam int SUM_OUT_W   = 48;
  localparam int SEXT_W      = 64;
  localparam int RECIP_SHIFT = 24;
  localparam int QM_W        = IDX_W + RECIP_SHIFT;
  localparam int QV_W        = 2 * IDX_W;
  localparam int FIFO_DEPTH  = 2;
  localparam int CORNERS     = 3;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [NRM_W-1:0] nrm_t;

  // One classified triangle: reduced corner indices and its face normal.
  typedef struct packed {
    idx_t idx_a;
    idx_t idx_b;
    idx_t idx_c;
    nrm_t nx;
    nrm_t ny;
    nrm_t nz;
  } tri_t;

  typedef enum logic [1:0] {
    CORNER_A,
    CORNER_B,
    CORNER_C
  } corner_e;

endpackage

@@ design/vna_front.sv @@
// ----------------------------------------------------------------------------
// Vertex normal accumulator front end
// Takes triangle requests, forms the face normal in a three-stage pipeline
// and reduces the corner indices into the vertex range.
// ----------------------------------------------------------------------------
module vna_front import vna_pkg::*; #(
  parameter int VERTEX_COUNT = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [IDX_W-1:0]          idx_a_i,
  input  logic [IDX_W-1:0]          idx_b_i,
  input  logic [IDX_W-1:0]          idx_c_i,
  input  logic signed [COORD_W-1:0] ax_i,
  input  logic signed [COORD_W-1:0] ay_i,
  input  logic signed [COORD_W-1:0] az_i,
  input  logic signed [COORD_W-1:0] bx_i,
  input  logic signed [COORD_W-1:0] by_coord_i,
  input  logic signed [COORD_W-1:0] bz_i,
  input  logic signed [COORD_W-1:0] cx_i,
  input  logic signed [COORD_W-1:0] cy_i,
  input  logic signed [COORD_W-1:0] cz_i,
  input  logic                      clearing_i,
  input  logic                      full_i,
  output logic                      push_o,
  output tri_t                      push_data_o
);

  logic advance;
  logic accept;
  logic v1_q, v2_q, v3_q;

  logic signed [EDGE_W-1:0] u_q [CORNERS];
  logic signed [EDGE_W-1:0] w_q [CORNERS];
  logic signed [PROD_W-1:0] p_q [2*CORNERS];
  nrm_t                     n_q [CORNERS];
  idx_t                     idx1_q [CORNERS];
  idx_t                     idx2_q [CORNERS];
  idx_t                     idx3_q [CORNERS];
  idx_t                     red_idx [CORNERS];

  // The whole pipeline holds while the last stage cannot hand off.
  assign advance = !(v3_q && full_i);
  assign busy_o  = clearing_i || !advance;
  assign accept  = start_i && !busy_o;
  assign push_o  = v3_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      // u = C - A, w = B - A
      u_q[0] <= EDGE_W'(cx_i) - EDGE_W'(ax_i);
      u_q[1] <= EDGE_W'(cy_i) - EDGE_W'(ay_i);
      u_q[2] <= EDGE_W'(cz_i) - EDGE_W'(az_i);
      w_q[0] <= EDGE_W'(bx_i) - EDGE_W'(ax_i);
      w_q[1] <= EDGE_W'(by_coord_i) - EDGE_W'(ay_i);
      w_q[2] <= EDGE_W'(bz_i) - EDGE_W'(az_i);
      idx1_q[0] <= idx_a_i;
      idx1_q[1] <= idx_b_i;
      idx1_q[2] <= idx_c_i;

      p_q[0] <= PROD_W'(u_q[1]) * PROD_W'(w_q[2]);
      p_q[1] <= PROD_W'(u_q[2]) * PROD_W'(w_q[1]);
      p_q[2] <= PROD_W'(u_q[2]) * PROD_W'(w_q[0]);
      p_q[3] <= PROD_W'(u_q[0]) * PROD_W'(w_q[2]);
      p_q[4] <= PROD_W'(u_q[0]) * PROD_W'(w_q[1]);
      p_q[5] <= PROD_W'(u_q[1]) * PROD_W'(w_q[0]);
      idx2_q <= idx1_q;

      n_q[0] <= NRM_W'(p_q[0]) - NRM_W'(p_q[1]);
      n_q[1] <= NRM_W'(p_q[2]) - NRM_W'(p_q[3]);
      n_q[2] <= NRM_W'(p_q[4]) - NRM_W'(p_q[5]);
      idx3_q <= idx2_q;
    end
  end

  for (genvar i = 0; i < CORNERS; i++) begin : g_lane
    if (VERTEX_COUNT >= (1 << IDX_W)) begin : g_pass
      assign red_idx[i] = idx3_q[i];
    end else begin : g_mod
      localparam int RECIP = (1 << RECIP_SHIFT) / VERTEX_COUNT;
      logic [QM_W-1:0]  qm;
      logic [QV_W-1:0]  qvm;
      logic [IDX_W-1:0] q_q;
      logic [IDX_W-1:0] qv_q;
      logic [IDX_W-1:0] rem;

      // The truncated reciprocal underestimates the quotient by at most one,
      // so a single conditional subtract finishes the remainder.
      assign qm  = QM_W'(idx1_q[i]) * QM_W'(RECIP);
      assign qvm = QV_W'(q_q) * QV_W'(VERTEX_COUNT);
      assign rem = idx3_q[i] - qv_q;
      assign red_idx[i] = (rem >= IDX_W'(VERTEX_COUNT)) ? rem - IDX_W'(VERTEX_COUNT) : rem;

      always_ff @(posedge clk_i) begin
        if (advance) begin
          q_q  <= qm[QM_W-1:RECIP_SHIFT];
          qv_q <= qvm[IDX_W-1:0];
        end
      end
    end
  end

  always_comb begin
    push_data_o.idx_a = red_idx[0];
    push_data_o.idx_b = red_idx[1];
    push_data_o.idx_c = red_idx[2];
    push_data_o.nx    = n_q[0];
    push_data_o.ny    = n_q[1];
    push_data_o.nz    = n_q[2];
  end

endmodule

@@ design/vna_fifo.sv @@
// ----------------------------------------------------------------------------
// Vertex normal accumulator triangle queue
// Short queue that decouples normal computation from the vertex updates.
// ----------------------------------------------------------------------------
module vna_fifo import vna_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tri_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output tri_t pop_data_o,
  output logic empty_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  tri_t             fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o     = (count_q == CNT_W'(FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ design/vna_back.sv @@
// ----------------------------------------------------------------------------
// Vertex normal accumulator back end
// Runs one read-modify-write per corner against the sum and flag memories,
// saturates the sums and drives the result strobe.
// ----------------------------------------------------------------------------
`include "vertex_normal_accumulator_macros.svh"

module vna_back import vna_pkg::*; #(
  parameter int VERTEX_COUNT = 4096,
  parameter int ACC_WIDTH    = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  output logic                        pop_o,
  input  tri_t                        pop_data_i,
  output logic                        clearing_o,
  output logic                        done_o,
  output logic [IDX_W-1:0]            vertex_index_o,
  output logic signed [SUM_OUT_W-1:0] sum_x_o,
  output logic signed [SUM_OUT_W-1:0] sum_y_o,
  output logic signed [SUM_OUT_W-1:0] sum_z_o,
  output logic                        clipped_o,
  output logic                        last_corner_o
);

  localparam int AW = $clog2(VERTEX_COUNT);

  // Clear pass over the set flags after reset.
  logic          clear_q;
  logic [AW-1:0] clr_cnt_q;

  // Read stage: current triangle and corner.
  corner_e corner_q;
  logic    tri_v_q;
  tri_t    tri_q;
  idx_t    cur_idx;
  logic [AW-1:0] raddr;

  // Update stage.
  logic    e_v_q;
  idx_t    e_idx_q;
  logic    e_last_q;
  nrm_t    e_n_q [CORNERS];
  logic [AW-1:0] e_addr;

  logic [CORNERS-1:0][ACC_WIDTH-1:0] sum_mem [VERTEX_COUNT];
  logic [CORNERS-1:0][ACC_WIDTH-1:0] rd_q;
  logic [CORNERS-1:0][ACC_WIDTH-1:0] new_word;
  logic                              flag_mem [VERTEX_COUNT];
  logic                              flag_rd_q;
  logic                              flag_we;
  logic [AW-1:0]                     flag_waddr;

  logic                 fwd;
  logic                 flag_eff;
  logic [CORNERS-1:0]   clip_lane;

  // Result registers, which also forward the last written sum.
  logic                        out_valid_q;
  idx_t                        out_idx_q;
  logic signed [ACC_WIDTH-1:0] out_sum_q [CORNERS];
  logic                        out_clip_q;
  logic                        out_last_q;
  logic signed [SUM_OUT_W-1:0] sum_o [CORNERS];

  assign clearing_o = clear_q;
  assign pop_o      = !clear_q && !empty_i && (!tri_v_q || corner_q == CORNER_C);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clear_q) begin
      if (clr_cnt_q == AW'(VERTEX_COUNT - 1)) begin
        clear_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_v_q  <= 1'b0;
      corner_q <= CORNER_A;
    end else if (pop_o) begin
      tri_v_q  <= 1'b1;
      corner_q <= CORNER_A;
    end else if (tri_v_q) begin
      unique case (corner_q)
        CORNER_A: corner_q <= CORNER_B;
        CORNER_B: corner_q <= CORNER_C;
        CORNER_C: begin
          tri_v_q  <= 1'b0;
          corner_q <= CORNER_A;
        end
        default:  corner_q <= CORNER_A;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tri_q <= pop_data_i;
    end
  end

  always_comb begin
    unique case (corner_q)
      CORNER_A: cur_idx = tri_q.idx_a;
      CORNER_B: cur_idx = tri_q.idx_b;
      CORNER_C: cur_idx = tri_q.idx_c;
      default:  cur_idx = tri_q.idx_a;
    endcase
  end

  assign raddr  = AW'(cur_idx);
  assign e_addr = AW'(e_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      e_v_q       <= tri_v_q;
      out_valid_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_idx_q  <= cur_idx;
    e_last_q <= (corner_q == CORNER_C);
    e_n_q[0] <= tri_q.nx;
    e_n_q[1] <= tri_q.ny;
    e_n_q[2] <= tri_q.nz;
  end

  // Sum memory: one read and one write port, registered read data. A read
  // issued in the same cycle as a write to that entry returns the old data;
  // the update stage forwards from the result registers in that case.
  always_ff @(posedge clk_i) begin
    if (e_v_q) begin
      sum_mem[e_addr] <= new_word;
    end
    rd_q <= sum_mem[raddr];
  end

  assign flag_we    = clear_q || e_v_q;
  assign flag_waddr = clear_q ? clr_cnt_q : e_addr;

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= !clear_q;
    end
    flag_rd_q <= flag_mem[raddr];
  end

  assign fwd      = out_valid_q && (out_idx_q == e_idx_q);
  assign flag_eff = fwd || flag_rd_q;

  for (genvar k = 0; k < CORNERS; k++) begin : g_comp
    logic signed [ACC_WIDTH-1:0] cur;
    logic signed [ACC_WIDTH-1:0] n_ext;
    logic [ACC_WIDTH:0]          sw;
    logic                        ovf;
    logic [ACC_WIDTH-1:0]        sat;
    logic signed [SEXT_W-1:0]    wide;

    assign cur   = fwd ? out_sum_q[k] : $signed(rd_q[k]);
    assign n_ext = ACC_WIDTH'(e_n_q[k]);
    assign sw    = {cur[ACC_WIDTH-1], cur} + {n_ext[ACC_WIDTH-1], n_ext};
    assign ovf   = sw[ACC_WIDTH] ^ sw[ACC_WIDTH-1];
    assign sat   = ovf ? {sw[ACC_WIDTH], {(ACC_WIDTH-1){~sw[ACC_WIDTH]}}}
                       : sw[ACC_WIDTH-1:0];

    // A first write loads the normal as is; it fits the accumulator when ACC_WIDTH is at least NRM_W.
    assign new_word[k]  = flag_eff ? sat : n_ext;
    assign clip_lane[k] = flag_eff && ovf;

    assign wide     = SEXT_W'(out_sum_q[k]);
    assign sum_o[k] = wide[SUM_OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    out_idx_q    <= e_idx_q;
    out_sum_q[0] <= new_word[0];
    out_sum_q[1] <= new_word[1];
    out_sum_q[2] <= new_word[2];
    out_clip_q   <= |clip_lane;
    out_last_q   <= e_last_q;
  end

  assign done_o         = out_valid_q;
  assign vertex_index_o = out_idx_q;
  assign sum_x_o        = sum_o[0];
  assign sum_y_o        = sum_o[1];
  assign sum_z_o        = sum_o[2];
  assign clipped_o      = out_clip_q;
  assign last_corner_o  = out_last_q;

  `VNA_ASSERT_IMP(a_clear_idle, clk_i, rst_ni, clear_q, !e_v_q && !pop_o && !tri_v_q, "vertex update during flag clear pass")
  `VNA_ASSERT_IMP(a_last_after_two, clk_i, rst_ni, out_valid_q && out_last_q, $past(out_valid_q) && !$past(out_last_q), "last corner result not preceded by its other corners")
  `VNA_ASSERT_NXT(a_first_no_clip, clk_i, rst_ni, e_v_q && !flag_eff, !out_clip_q, "first write of a vertex reported saturation")

endmodule

@@ design/vertex_normal_accumulator.sv @@
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// Area-weighted per-vertex normal sums from a stream of triangle requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each triangle gives
// three results, for corners A, B and C, on consecutive cycles marked by
// done_o; the receiver cannot stall them. The update unit handles one corner
// per cycle as a read-modify-write of the vertex sum memory, so a triangle
// occupies it for its three corners in turn; a queued triangle follows right
// after corner C. With the update unit idle, a request goes through the front
// end stages, the queue, the read and update stages and result registers.
// After reset busy stays high while the per-vertex set flags are cleared.
module vertex_normal_accumulator import vna_pkg::*; #(
  parameter int VERTEX_COUNT = 4096,
  parameter int ACC_WIDTH    = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [IDX_W-1:0]            idx_a_i,
  input  logic [IDX_W-1:0]            idx_b_i,
  input  logic [IDX_W-1:0]            idx_c_i,
  input  logic signed [COORD_W-1:0]   ax_i,
  input  logic signed [COORD_W-1:0]   ay_i,
  input  logic signed [COORD_W-1:0]   az_i,
  input  logic signed [COORD_W-1:0]   bx_i,
  input  logic signed [COORD_W-1:0]   by_coord_i,
  input  logic signed [COORD_W-1:0]   bz_i,
  input  logic signed [COORD_W-1:0]   cx_i,
  input  logic signed [COORD_W-1:0]   cy_i,
  input  logic signed [COORD_W-1:0]   cz_i,
  output logic                        done_o,
  output logic [IDX_W-1:0]            vertex_index_o,
  output logic signed [SUM_OUT_W-1:0] sum_x_o,
  output logic signed [SUM_OUT_W-1:0] sum_y_o,
  output logic signed [SUM_OUT_W-1:0] sum_z_o,
  output logic                        clipped_o,
  output logic                        last_corner_o
);

  logic clearing;
  logic full;
  logic empty;
  logic push;
  logic pop;
  tri_t push_data;
  tri_t pop_data;

  vna_front #(
    .VERTEX_COUNT(VERTEX_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .idx_a_i     (idx_a_i),
    .idx_b_i     (idx_b_i),
    .idx_c_i     (idx_c_i),
    .ax_i        (ax_i),
    .ay_i        (ay_i),
    .az_i        (az_i),
    .bx_i        (bx_i),
    .by_coord_i  (by_coord_i),
    .bz_i        (bz_i),
    .cx_i        (cx_i),
    .cy_i        (cy_i),
    .cz_i        (cz_i),
    .clearing_i  (clearing),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  vna_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  vna_back #(
    .VERTEX_COUNT(VERTEX_COUNT),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .pop_o          (pop),
    .pop_data_i     (pop_data),
    .clearing_o     (clearing),
    .done_o         (done_o),
    .vertex_index_o (vertex_index_o),
    .sum_x_o        (sum_x_o),
    .sum_y_o        (sum_y_o),
    .sum_z_o        (sum_z_o),
    .clipped_o      (clipped_o),
    .last_corner_o  (last_corner_o)
  );

endmodule
